### hdl/vrsb_pkg.sv
package vrsb_pkg;

    localparam int SCREEN_W = 320;
    localparam int SCREEN_H = 200;

    localparam int POINT_W  = 19;   // full-width screen coordinate after centering
    localparam int Q_DEPTH  = 4;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int REG_IDX_W = 3;

    localparam logic signed [POINT_W-1:0] CENTER_X = POINT_W'(SCREEN_W / 2);
    localparam logic signed [POINT_W-1:0] CENTER_Y = POINT_W'(SCREEN_H / 2);

    localparam logic signed [15:0] SCREEN_W_16  = 16'(SCREEN_W);
    localparam logic signed [15:0] SCREEN_H_16  = 16'(SCREEN_H);
    localparam logic signed [15:0] BOX_EMPTY_MIN = 16'sh7FFF;
    localparam logic signed [15:0] BOX_EMPTY_MAX = 16'sh8000;
    localparam logic        [15:0] ALIGN_MASK   = 16'hFFF0;

    localparam logic signed [15:0] COSINE_RESET   = 16'sh7FFF;
    localparam logic signed [15:0] SINE_RESET     = 16'sh0000;
    localparam logic        [15:0] SCALE_RESET    = 16'h0000;
    localparam logic signed [15:0] X_SHIFT_RESET  = 16'sh0000;
    localparam logic signed [11:0] Y_OFFSET_RESET = -12'sd27;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COSINE   = 3'd0,
        REG_SINE     = 3'd1,
        REG_SCALE    = 3'd2,
        REG_X_SHIFT  = 3'd3,
        REG_Y_OFFSET = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_POLY  = 2'd1,
        KIND_FRAME = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        BK_POINT,
        BK_POLY,
        BK_FRAME
    } back_state_t;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] polygon_x_offset;
        logic               polygon_end;
        logic               frame_end;
    } in_word_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] box_min_x;
        logic signed [15:0] box_max_x;
        logic signed [15:0] box_min_y;
        logic signed [15:0] box_max_y;
        logic               culled;
        logic               last;
    } out_word_t;

    // transformed vertex as it travels from front to back
    typedef struct packed {
        logic signed [POINT_W-1:0] sx;
        logic signed [POINT_W-1:0] sy;
        logic                      pend;
        logic                      fend;
    } point_t;

    typedef struct packed {
        logic   push;
        point_t data;
    } q_wr_t;

    typedef struct packed {
        logic   empty;
        point_t data;
    } q_rd_t;

endpackage

### hdl/vrsb_front.sv
module vrsb_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  vrsb_pkg::in_word_t                  vertex,
    input  logic                                wr_en,
    input  logic [vrsb_pkg::REG_IDX_W-1:0]      wr_index,
    input  logic [15:0]                         wr_data,
    output vrsb_pkg::q_wr_t                     q_wr,
    input  logic                                q_full
);
    import vrsb_pkg::*;

    logic signed [15:0] cosine_reg;
    logic signed [15:0] sine_reg;
    logic        [15:0] scale_reg;
    logic signed [15:0] x_shift_reg;
    logic signed [11:0] y_offset_reg;

    logic               v0_reg, v1_reg, v2_reg, v3_reg;
    logic [1:0]         f0_reg, f1_reg, f2_reg, f3_reg;   // {pend, fend}
    logic signed [15:0] x_reg, y_reg;
    logic signed [31:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic signed [16:0] rx_reg, ry_reg;
    logic signed [33:0] mx_reg, my_reg;

    logic               adv;
    logic [15:0]        xsum, ysum;
    logic signed [15:0] x_next, y_next;
    logic signed [32:0] dx, dy;
    logic signed [33:0] mx_next, my_next;

    // the whole pipe holds while the last stage waits on the queue
    assign adv  = !(v3_reg && q_full);
    assign full = !adv;

    always_comb
    begin
        xsum    = vertex.vertex_x + vertex.polygon_x_offset;
        x_next  = {xsum[11:0], 4'b0000} + x_shift_reg;
        ysum    = vertex.vertex_y + {{4{y_offset_reg[11]}}, y_offset_reg};
        y_next  = {ysum[11:0], 4'b0000};
        dx      = $signed({pxc_reg[31], pxc_reg}) - $signed({pys_reg[31], pys_reg});
        dy      = $signed({pxs_reg[31], pxs_reg}) + $signed({pyc_reg[31], pyc_reg});
        mx_next = rx_reg * $signed({1'b0, scale_reg});
        my_next = ry_reg * $signed({1'b0, scale_reg});
    end

    always_comb
    begin
        q_wr.push    = v3_reg && adv;
        q_wr.data.sx = $signed({mx_reg[33], mx_reg[33:16]}) + CENTER_X;
        q_wr.data.sy = $signed({my_reg[33], my_reg[33:16]}) + CENTER_Y;
        q_wr.data.pend = f3_reg[1];
        q_wr.data.fend = f3_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cosine_reg   <= COSINE_RESET;
            sine_reg     <= SINE_RESET;
            scale_reg    <= SCALE_RESET;
            x_shift_reg  <= X_SHIFT_RESET;
            y_offset_reg <= Y_OFFSET_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_COSINE:   cosine_reg   <= wr_data;
                REG_SINE:     sine_reg     <= wr_data;
                REG_SCALE:    scale_reg    <= wr_data;
                REG_X_SHIFT:  x_shift_reg  <= wr_data;
                REG_Y_OFFSET: y_offset_reg <= wr_data[11:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= push;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            f0_reg  <= {vertex.polygon_end | vertex.frame_end, vertex.frame_end};
            pxc_reg <= x_reg * cosine_reg;
            pys_reg <= y_reg * sine_reg;
            pxs_reg <= x_reg * sine_reg;
            pyc_reg <= y_reg * cosine_reg;
            f1_reg  <= f0_reg;
            rx_reg  <= dx[32:16];
            ry_reg  <= dy[32:16];
            f2_reg  <= f1_reg;
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            f3_reg  <= f2_reg;
        end
    end

endmodule

### hdl/vrsb_queue.sv
module vrsb_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  vrsb_pkg::q_wr_t  q_wr,
    output logic             q_full,
    input  logic             q_pop,
    output vrsb_pkg::q_rd_t  q_rd
);
    import vrsb_pkg::*;

    point_t            entry_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push, do_pop;

    assign q_full     = (count_reg == (QPTR_W+1)'(Q_DEPTH));
    assign q_rd.empty = (count_reg == '0);
    assign q_rd.data  = entry_reg[rd_ptr_reg];
    assign do_push    = q_wr.push && !q_full;
    assign do_pop     = q_pop && !q_rd.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= q_wr.data;
    end

endmodule

### hdl/vrsb_back.sv
module vrsb_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vrsb_pkg::q_rd_t      q_rd,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output vrsb_pkg::out_word_t  result
);
    import vrsb_pkg::*;

    back_state_t        state_reg, state_next;
    logic               cur_valid_reg;
    point_t             cur_reg;
    logic               out_valid_reg;
    out_word_t          out_reg;

    logic signed [15:0] p_min_x_reg, p_max_x_reg, p_min_y_reg, p_max_y_reg;
    logic signed [15:0] f_min_x_reg, f_max_x_reg, f_min_y_reg, f_max_y_reg;

    logic               out_load, emit, done, load_cur;
    out_word_t          word;
    logic signed [15:0] mn, mx, mn_h, mx_h, diff, cnt;
    logic               culled;

    assign out_load = !out_valid_reg || pop;
    assign emit     = cur_valid_reg && out_load;
    assign q_pop    = !cur_valid_reg || done;
    assign load_cur = q_pop && !q_rd.empty;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_POINT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        done       = 1'b0;
        state_next = state_reg;
        if (emit)
        begin
            unique case (state_reg)
                BK_POINT:
                begin
                    done       = !cur_reg.pend;
                    state_next = BK_POLY;
                end
                BK_POLY:
                begin
                    done       = !cur_reg.fend;
                    state_next = BK_FRAME;
                end
                BK_FRAME:
                begin
                    done       = 1'b1;
                    state_next = BK_POINT;
                end
                default:
                begin
                    done       = 1'b1;
                    state_next = BK_POINT;
                end
            endcase
        end
        if (q_pop)
            state_next = BK_POINT;
    end

    // frame box reduced to an aligned byte offset and a word count, plus the polygon cull test
    always_comb
    begin
        mn = (f_min_x_reg < 16'sd0) ? 16'sd0 : f_min_x_reg;
        mx = (f_max_x_reg >= SCREEN_W_16) ? (SCREEN_W_16 - 16'sd1) : f_max_x_reg;
        mn_h = $signed(mn & ALIGN_MASK) >>> 1;
        mx_h = $signed(mx & ALIGN_MASK) >>> 1;
        diff = mx_h - mn_h;
        cnt  = (diff >>> 3) + 16'sd1;
        culled = (p_max_y_reg < 16'sd0) || (p_min_y_reg >= SCREEN_H_16) ||
                 (p_max_x_reg < 16'sd0) || (p_min_x_reg >= SCREEN_W_16);
    end

    always_comb
    begin
        word = '0;
        unique case (state_reg)
            BK_POINT:
            begin
                word.kind    = KIND_POINT;
                word.point_x = cur_reg.sx[15:0];
                word.point_y = cur_reg.sy[15:0];
                word.last    = !cur_reg.pend;
            end
            BK_POLY:
            begin
                word.kind      = KIND_POLY;
                word.box_min_x = p_min_x_reg;
                word.box_max_x = p_max_x_reg;
                word.box_min_y = p_min_y_reg;
                word.box_max_y = p_max_y_reg;
                word.culled    = culled;
                word.last      = !cur_reg.fend;
            end
            BK_FRAME:
            begin
                word.kind      = KIND_FRAME;
                word.box_min_x = mn_h;
                word.box_max_x = cnt;
                word.box_min_y = f_min_y_reg;
                word.box_max_y = f_max_y_reg;
                word.last      = 1'b1;
            end
            default:
                word = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
                cur_valid_reg <= !q_rd.empty;
            if (out_load)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_cur)
            cur_reg <= q_rd.data;
        if (emit)
            out_reg <= word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_min_x_reg <= BOX_EMPTY_MIN;
            p_max_x_reg <= BOX_EMPTY_MAX;
            p_min_y_reg <= BOX_EMPTY_MIN;
            p_max_y_reg <= BOX_EMPTY_MAX;
            f_min_x_reg <= BOX_EMPTY_MIN;
            f_max_x_reg <= BOX_EMPTY_MAX;
            f_min_y_reg <= BOX_EMPTY_MIN;
            f_max_y_reg <= BOX_EMPTY_MAX;
        end
        else if (emit)
        begin
            unique case (state_reg)
                BK_POINT:
                begin
                    // compare at full width, keep the low 16 bits
                    if (cur_reg.sx < POINT_W'(p_min_x_reg))
                        p_min_x_reg <= cur_reg.sx[15:0];
                    if (cur_reg.sx > POINT_W'(p_max_x_reg))
                        p_max_x_reg <= cur_reg.sx[15:0];
                    if (cur_reg.sy < POINT_W'(p_min_y_reg))
                        p_min_y_reg <= cur_reg.sy[15:0];
                    if (cur_reg.sy > POINT_W'(p_max_y_reg))
                        p_max_y_reg <= cur_reg.sy[15:0];
                end
                BK_POLY:
                begin
                    if (f_min_x_reg > p_min_x_reg)
                        f_min_x_reg <= p_min_x_reg;
                    if (f_max_x_reg < p_max_x_reg)
                        f_max_x_reg <= p_max_x_reg;
                    if (f_min_y_reg > p_min_y_reg)
                        f_min_y_reg <= p_min_y_reg;
                    if (f_max_y_reg < p_max_y_reg)
                        f_max_y_reg <= p_max_y_reg;
                    p_min_x_reg <= BOX_EMPTY_MIN;
                    p_max_x_reg <= BOX_EMPTY_MAX;
                    p_min_y_reg <= BOX_EMPTY_MIN;
                    p_max_y_reg <= BOX_EMPTY_MAX;
                end
                BK_FRAME:
                begin
                    f_min_x_reg <= BOX_EMPTY_MIN;
                    f_max_x_reg <= BOX_EMPTY_MAX;
                    f_min_y_reg <= BOX_EMPTY_MIN;
                    f_max_y_reg <= BOX_EMPTY_MAX;
                end
                default: ;
            endcase
        end
    end

endmodule

### hdl/vertex_rotate_scale_bbox_cull_core.sv
// Vertex transform with polygon and frame bounding boxes. Each vertex word
// pushed in yields one screen point word, plus a polygon box word at the end
// of a polygon and a frame box word at the end of a frame, all popped in that
// order. A vertex passes a four-stage front (offset and shift, rotation
// products, rotation sums, zoom products) and waits in a four-entry queue;
// the back puts out one result word per cycle, while pop is held, through a
// single output register; a vertex that yields more words holds it longer.
// A vertex's first word passes the four front stages, the queue, the current
// vertex register and output register. Registers are written through wr_en,
// wr_index and wr_data and must be changed only while no vertex is in flight.
module vertex_rotate_scale_bbox_cull_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  vrsb_pkg::in_word_t                  vertex,
    output logic                                empty,
    input  logic                                pop,
    output vrsb_pkg::out_word_t                 result,
    input  logic                                wr_en,
    input  logic [vrsb_pkg::REG_IDX_W-1:0]      wr_index,
    input  logic [15:0]                         wr_data
);
    import vrsb_pkg::*;

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  q_pop;

    vrsb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .vertex   (vertex),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .q_wr     (q_wr),
        .q_full   (q_full)
    );

    vrsb_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .q_pop  (q_pop),
        .q_rd   (q_rd)
    );

    vrsb_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_rd   (q_rd),
        .q_pop  (q_pop),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    a_no_push_into_full_queue: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_wr.push |-> !q_full
    ) else $error("front pushed into a full queue");

    a_frame_box_is_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == KIND_FRAME) |-> result.last
    ) else $error("frame box word not marked last");

    a_culled_only_on_polygon: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && result.culled) |-> (result.kind == KIND_POLY)
    ) else $error("culled flag on a word that is not a polygon box");

endmodule

### verif/vertex_rotate_scale_bbox_cull_core_tb.sv
module vertex_rotate_scale_bbox_cull_core_tb;
    import vrsb_pkg::*;

    localparam int TOTAL_ITEMS    = 430;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIR_ROWS       = 30;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd5;

    typedef enum bit {ROW_VTX, ROW_CFG} row_op_t;
    typedef enum int {SET_EXTREME, SET_RANDOM, SET_NEAR} setting_t;

    typedef struct {
        row_op_t              op;
        logic [REG_IDX_W-1:0] idx;
        logic [15:0]          data;
        in_word_t             vtx;
        bit                   typed;
        logic signed [15:0]   px;
        logic signed [15:0]   py;
    } row_t;

    typedef struct packed {
        logic signed [15:0] min_x;
        logic signed [15:0] max_x;
        logic signed [15:0] min_y;
        logic signed [15:0] max_y;
    } box_t;

    localparam box_t EMPTY_BOX = '{BOX_EMPTY_MIN, BOX_EMPTY_MAX, BOX_EMPTY_MIN, BOX_EMPTY_MAX};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    in_word_t             vertex = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    out_word_t            result;
    logic                 wr_en = 1'b0;
    logic [REG_IDX_W-1:0] wr_index = '0;
    logic [15:0]          wr_data = '0;

    // predictor copy of the registers and boxes
    logic signed [15:0] cos_q15  = COSINE_RESET;
    logic signed [15:0] sin_q15  = SINE_RESET;
    logic        [15:0] zoom     = SCALE_RESET;
    logic signed [15:0] shift_x  = X_SHIFT_RESET;
    logic signed [11:0] offset_y = Y_OFFSET_RESET;
    box_t               poly_box  = EMPTY_BOX;
    box_t               frame_box = EMPTY_BOX;

    out_word_t expected_words[$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        items_sent = 0;
    bit        tx_idle_on = 1'b0;
    bit        rx_idle_on = 1'b0;
    bit        rx_hold_req = 1'b0;

    row_t dir_rows [DIR_ROWS];

    vertex_rotate_scale_bbox_cull_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .vertex   (vertex),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap(input bit on);
        int r;
        r = $urandom_range(0, 99);
        if (!on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Work out the words one vertex yields and advance the box state.
    function automatic void transform_vertex(input in_word_t v, input bit typed,
                                             input logic signed [15:0] tx,
                                             input logic signed [15:0] ty);
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] mn;
        logic signed [15:0] mx;
        longint             rx;
        longint             ry;
        longint             scx;
        longint             scy;
        bit                 pend;
        out_word_t          w;
        pend = v.polygon_end | v.frame_end;
        x = v.vertex_x + v.polygon_x_offset;
        x = x <<< 4;
        x = x + shift_x;
        y = v.vertex_y + offset_y;
        y = y <<< 4;
        rx = (longint'(x) * longint'(cos_q15) - longint'(y) * longint'(sin_q15)) >>> 16;
        ry = (longint'(x) * longint'(sin_q15) + longint'(y) * longint'(cos_q15)) >>> 16;
        scx = ((rx * longint'(zoom)) >>> 16) + SCREEN_W / 2;
        scy = ((ry * longint'(zoom)) >>> 16) + SCREEN_H / 2;

        w = '0;
        w.kind    = KIND_POINT;
        w.point_x = scx[15:0];
        w.point_y = scy[15:0];
        w.last    = !pend;
        if (typed)
        begin
            w.point_x = tx;
            w.point_y = ty;
        end
        expected_words.push_back(w);

        // compare at full width, store the low 16 bits
        if (scx < longint'(poly_box.min_x)) poly_box.min_x = scx[15:0];
        if (scx > longint'(poly_box.max_x)) poly_box.max_x = scx[15:0];
        if (scy < longint'(poly_box.min_y)) poly_box.min_y = scy[15:0];
        if (scy > longint'(poly_box.max_y)) poly_box.max_y = scy[15:0];

        if (pend)
        begin
            if (poly_box.min_x < frame_box.min_x) frame_box.min_x = poly_box.min_x;
            if (poly_box.max_x > frame_box.max_x) frame_box.max_x = poly_box.max_x;
            if (poly_box.min_y < frame_box.min_y) frame_box.min_y = poly_box.min_y;
            if (poly_box.max_y > frame_box.max_y) frame_box.max_y = poly_box.max_y;
            w = '0;
            w.kind      = KIND_POLY;
            w.box_min_x = poly_box.min_x;
            w.box_max_x = poly_box.max_x;
            w.box_min_y = poly_box.min_y;
            w.box_max_y = poly_box.max_y;
            w.culled    = poly_box.max_y < 0 || poly_box.min_y >= SCREEN_H_16 ||
                          poly_box.max_x < 0 || poly_box.min_x >= SCREEN_W_16;
            w.last      = !v.frame_end;
            expected_words.push_back(w);
            poly_box = EMPTY_BOX;
        end

        if (v.frame_end)
        begin
            mn = frame_box.min_x;
            mx = frame_box.max_x;
            if (mn < 0)
                mn = 16'sd0;
            if (mx >= SCREEN_W_16)
                mx = SCREEN_W_16 - 16'sd1;
            mn = mn & ALIGN_MASK;
            mn = mn >>> 1;
            mx = mx & ALIGN_MASK;
            mx = mx >>> 1;
            mx = mx - mn;
            mx = mx >>> 3;
            mx = mx + 16'sd1;
            w = '0;
            w.kind      = KIND_FRAME;
            w.box_min_x = mn;
            w.box_max_x = mx;
            w.box_min_y = frame_box.min_y;
            w.box_max_y = frame_box.max_y;
            w.last      = 1'b1;
            expected_words.push_back(w);
            frame_box = EMPTY_BOX;
        end
    endfunction

    function automatic void cmp_field(input string name, input logic [15:0] e,
                                      input logic [15:0] a);
        if (a !== e)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
        end
    endfunction

    task automatic check_word(input out_word_t got);
        out_word_t exp_w;
        if (expected_words.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected word, expected none, actual %h", $time, got);
        end
        else
        begin
            exp_w = expected_words.pop_front();
            cmp_field("kind",      16'(exp_w.kind),   16'(got.kind));
            cmp_field("point_x",   exp_w.point_x,     got.point_x);
            cmp_field("point_y",   exp_w.point_y,     got.point_y);
            cmp_field("box_min_x", exp_w.box_min_x,   got.box_min_x);
            cmp_field("box_max_x", exp_w.box_max_x,   got.box_max_x);
            cmp_field("box_min_y", exp_w.box_min_y,   got.box_min_y);
            cmp_field("box_max_y", exp_w.box_max_y,   got.box_max_y);
            cmp_field("culled",    16'(exp_w.culled), 16'(got.culled));
            cmp_field("last",      16'(exp_w.last),   16'(got.last));
        end
    endtask

    task automatic send_vertex(input in_word_t v, input bit typed = 1'b0,
                               input logic signed [15:0] tx = '0,
                               input logic signed [15:0] ty = '0);
        int gap;
        gap = pick_gap(tx_idle_on);
        wr_en <= 1'b0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push   <= 1'b1;
        vertex <= v;
        do @(posedge clk); while (full);
        transform_vertex(v, typed, tx, ty);
        items_sent++;
    endtask

    // Hold the input low until every expected word has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge clk); while (expected_words.size() != 0);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        case (idx)
            REG_COSINE:   cos_q15  = data;
            REG_SINE:     sin_q15  = data;
            REG_SCALE:    zoom     = data;
            REG_X_SHIFT:  shift_x  = data;
            REG_Y_OFFSET: offset_y = data[11:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input setting_t mode);
        logic [15:0] c;
        logic [15:0] s;
        logic [15:0] z;
        logic [15:0] xs;
        logic [15:0] yo;
        wait_drained();
        case (mode)
            SET_EXTREME:
            begin
                c  = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                s  = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                z  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                xs = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                yo = {4'($urandom), $urandom_range(0, 1) ? 12'h800 : 12'h7FF};
            end
            SET_RANDOM:
            begin
                c  = 16'($urandom);
                s  = 16'($urandom);
                z  = 16'($urandom);
                xs = 16'($urandom);
                yo = 16'($urandom);
            end
            default:
            begin
                c  = 16'($urandom_range(16'h6000, 16'h7FFF));
                s  = 16'($urandom_range(0, 16'h4000) - 16'h2000);
                z  = 16'($urandom_range(16'h4000, 16'hFFFF));
                xs = 16'($urandom_range(0, 512) - 256);
                yo = 16'($urandom_range(0, 128) - 64);
            end
        endcase
        write_reg(REG_COSINE, c);
        write_reg(REG_SINE, s);
        write_reg(REG_SCALE, z);
        write_reg(REG_X_SHIFT, xs);
        write_reg(REG_Y_OFFSET, yo);
        write_reg(REG_UNUSED + 3'($urandom_range(0, 2)), 16'($urandom));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                check_word(result);
            if (rx_hold_req)
            begin
                stall_left  = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 99) < 25)
                stall_left = pick_gap(1'b1);
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin : sender
        int       r;
        int       phase;
        int       n_frames;
        int       n_polys;
        int       n_verts;
        bit       pe;
        bit       fe;
        bit       pressure;
        in_word_t v;
        row_op_t  prev_op;

        // points land on the centre while the zoom is zero after reset
        dir_rows = '{
            '{ROW_VTX, '0, '0, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0}, 1'b1, 16'sd160, 16'sd100},
            '{ROW_VTX, '0, '0, '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 1'b0}, 1'b1, 16'sd160, 16'sd100},
            '{ROW_VTX, '0, '0, '{16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 1'b0}, 1'b1, 16'sd160, 16'sd100},
            // frame end alone still closes the polygon
            '{ROW_VTX, '0, '0, '{16'sh1234, 16'shFFFF, 16'sh0000, 1'b0, 1'b1}, 1'b1, 16'sd160, 16'sd100},
            '{ROW_VTX, '0, '0, '{16'sh5555, 16'shAAAA, 16'sh0F0F, 1'b1, 1'b1}, 1'b1, 16'sd160, 16'sd100},
            '{ROW_CFG, REG_COSINE,   16'h8000, '0, 1'b0, '0, '0},
            '{ROW_CFG, REG_SINE,     16'h7FFF, '0, 1'b0, '0, '0},
            '{ROW_CFG, REG_SCALE,    16'hFFFF, '0, 1'b0, '0, '0},
            '{ROW_CFG, REG_X_SHIFT,  16'h8000, '0, 1'b0, '0, '0},
            '{ROW_CFG, REG_Y_OFFSET, 16'hF7FF, '0, 1'b0, '0, '0},
            '{ROW_CFG, REG_UNUSED,   16'h1234, '0, 1'b0, '0, '0},
            // screen x runs past 0x7FFF, the box max keeps the wrapped value
            '{ROW_VTX, '0, '0, '{16'sh0000, 16'sh0001, 16'sh0000, 1'b1, 1'b0}, 1'b0, '0, '0},
            '{ROW_VTX, '0, '0, '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0, 1'b0}, 1'b0, '0, '0},
            '{ROW_VTX, '0, '0, '{16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1, 1'b1}, 1'b0, '0, '0},
            '{ROW_CFG, REG_COSINE,   16'h7FFF, '0, 1'b0, '0, '0},
            '{ROW_CFG, REG_SINE,     16'h8000, '0, 1'b0, '0, '0},
            '{ROW_CFG, REG_X_SHIFT,  16'h7FFF, '0, 1'b0, '0, '0},
            '{ROW_CFG, REG_Y_OFFSET, 16'h0800, '0, 1'b0, '0, '0},
            '{ROW_VTX, '0, '0, '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0}, 1'b0, '0, '0},
            '{ROW_VTX, '0, '0, '{16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0, 1'b1}, 1'b0, '0, '0},
            '{ROW_CFG, REG_SINE,     16'h0000, '0, 1'b0, '0, '0},
            '{ROW_CFG, REG_X_SHIFT,  16'h0000, '0, 1'b0, '0, '0},
            '{ROW_CFG, REG_Y_OFFSET, 16'h0000, '0, 1'b0, '0, '0},
            // a box on screen, then a box off each edge of the screen
            '{ROW_VTX, '0, '0, '{16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 1'b0}, 1'b0, '0, '0},
            '{ROW_VTX, '0, '0, '{16'shFFE2, 16'sh0000, 16'sh0000, 1'b1, 1'b0}, 1'b0, '0, '0},
            '{ROW_VTX, '0, '0, '{16'sh001E, 16'sh0000, 16'sh0000, 1'b1, 1'b0}, 1'b0, '0, '0},
            '{ROW_VTX, '0, '0, '{16'sh0000, 16'shFFF0, 16'sh0000, 1'b1, 1'b0}, 1'b0, '0, '0},
            '{ROW_VTX, '0, '0, '{16'sh0000, 16'sh0010, 16'sh0000, 1'b1, 1'b0}, 1'b0, '0, '0},
            // frame box clamped on both sides
            '{ROW_VTX, '0, '0, '{16'shFFE2, 16'shFFF6, 16'sh0000, 1'b0, 1'b0}, 1'b0, '0, '0},
            '{ROW_VTX, '0, '0, '{16'sh001E, 16'sh000A, 16'sh0000, 1'b0, 1'b1}, 1'b0, '0, '0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        prev_op = ROW_CFG;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].op == ROW_CFG)
            begin
                if (prev_op == ROW_VTX)
                    wait_drained();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end
            else
                send_vertex(dir_rows[i].vtx, dir_rows[i].typed, dir_rows[i].px, dir_rows[i].py);
            prev_op = dir_rows[i].op;
        end

        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            r = $urandom_range(0, 3);
            apply_setting(r == 0 ? SET_EXTREME : (r == 1 ? SET_RANDOM : SET_NEAR));
            tx_idle_on = (phase % 4 != 1) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (phase % 4 != 1) && ($urandom_range(0, 3) != 0);
            // stall the output long enough for the input side to back up
            pressure = (phase == 2) || (phase == 15);
            if (pressure)
            begin
                tx_idle_on  = 1'b0;
                rx_hold_req = 1'b1;
            end
            n_frames = pressure ? 3 : $urandom_range(1, 3);
            for (int f = 0; f < n_frames; f++)
            begin
                n_polys = pressure ? 4 : $urandom_range(1, 4);
                for (int p = 0; p < n_polys; p++)
                begin
                    n_verts = $urandom_range(1, 5);
                    for (int k = 0; k < n_verts; k++)
                    begin
                        pe = (k == n_verts - 1);
                        fe = pe && (p == n_polys - 1);
                        if (fe)
                            pe = 1'($urandom_range(0, 1));
                        if ($urandom_range(0, 9) == 0)
                        begin
                            pe = 1'($urandom_range(0, 1));
                            fe = ($urandom_range(0, 7) == 0);
                        end
                        if ($urandom_range(0, 9) < 7)
                        begin
                            v.vertex_x         = 16'($urandom_range(0, 80) - 40);
                            v.vertex_y         = 16'($urandom_range(0, 80) - 40);
                            v.polygon_x_offset = 16'($urandom_range(0, 40) - 20);
                        end
                        else
                        begin
                            v.vertex_x         = 16'($urandom);
                            v.vertex_y         = 16'($urandom);
                            v.polygon_x_offset = 16'($urandom);
                        end
                        v.polygon_end = pe;
                        v.frame_end   = fe;
                        send_vertex(v);
                    end
                end
            end
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### vertex_rotate_scale_bbox_cull_core.f
hdl/vrsb_pkg.sv
hdl/vrsb_front.sv
hdl/vrsb_queue.sv
hdl/vrsb_back.sv
hdl/vertex_rotate_scale_bbox_cull_core.sv
verif/vertex_rotate_scale_bbox_cull_core_tb.sv
